### design/sqrot_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the turn-selection function for the square
// image corner orientation block. No dependencies.
package sqrot_pkg;

	localparam int DEF_MAX_SIDE   = 64;
	localparam int DEF_PIXEL_BITS = 16;

	// fixed field widths at the ports
	localparam int PIX_W      = 16;
	localparam int CFG_W      = 7;
	localparam int OUT_USER_W = 3;
	localparam int SIDE_RESET = 64;

	typedef enum logic [1:0] {
		TURN_NONE  = 2'd0,
		TURN_ONE   = 2'd1,
		TURN_TWO   = 2'd2,
		TURN_THREE = 2'd3
	} turns_t;

	// zero-corner flags, top-right in bit 0
	typedef struct packed {
		logic bot_left;
		logic bot_right;
		logic top_right;
	} corner_flags_t;

	function automatic turns_t pick_turns(input corner_flags_t flags);
		turns_t t;
		if (flags.top_right)      t = TURN_ONE;
		else if (flags.bot_right) t = TURN_TWO;
		else if (flags.bot_left)  t = TURN_THREE;
		else                      t = TURN_NONE;
		return t;
	endfunction

endpackage

### design/sqrot_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module sqrot_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/square_image_corner_orient_rotate.sv
`timescale 1ns / 1ps
// Square image corner orientation: loads an image, turns it so a zero
// corner lands top-left, streams it out. Uses sqrot_pkg and sqrot_ram.
//
// Input stream (s_axis_*): tuser picks the beat kind. A load beat (tuser = 0)
//   carries one pixel in tdata, raster order, until image_side * image_side
//   pixels are in; further loads are dropped until the image is drained.
//   A read beat (tuser = 1) pulls the next pixel of the turned image; read
//   beats before the image is complete are dropped and produce nothing.
// Output stream (m_axis_*): one beat per answered read beat. tdata holds the
//   pixel, tlast marks a row end, tuser the image end and the quarter turns.
// Config: cfg_we/cfg_data set the side (0 acts as 1, above MAX_SIDE acts as
//   MAX_SIDE) and drop any image in progress.
// Timing: one beat per cycle in either direction while no stall holds it. A read beat's
//   result passes through the store read stage, then the output register.
// Reset: arst_n clears counters and flags, side returns to 64 (MAX_SIDE if
//   smaller). Store contents are not cleared; reads only hit the current image.
// Stall: with m_axis_tready low the output register holds, the read stage
//   holds behind it, and s_axis_tready drops once both are full.
module square_image_corner_orient_rotate
	import sqrot_pkg::*;
#(
	parameter int MAX_SIDE   = DEF_MAX_SIDE,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_data,      // image_side
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PIX_W-1:0]      s_axis_tdata,  // [15:0] pixel_in
	input  logic                  s_axis_tuser,  // [0] mode
	// output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PIX_W-1:0]      m_axis_tdata,  // [15:0] pixel_out
	output logic                  m_axis_tlast,  // row_end
	output logic [OUT_USER_W-1:0] m_axis_tuser   // [0] image_end, [2:1] turns_applied
);

	localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
	localparam int CW        = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int RST_SIDE  = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

	// side length, kept as n (for column strides) and n-1 (for end compares)
	logic [SIDE_W-1:0] side_q;
	logic [CW-1:0]     side_m1_q;
	logic [SIDE_W-1:0] side_new;
	logic [AW-1:0]     stride;

	// load side
	logic [CW-1:0]     ld_row_q, ld_col_q;
	logic [AW-1:0]     ld_addr_q;
	logic [AW-1:0]     last_addr_q;
	logic              full_q;
	corner_flags_t     flags_q;

	// read side
	logic [CW-1:0]     rd_row_q, rd_col_q;
	logic [AW-1:0]     rd_addr_q;
	logic [AW-1:0]     rd_rs_q;

	// store read stage and output register
	logic              valid_s1, row_end_s1, image_end_s1;
	turns_t            turns_s1;
	logic              out_valid_q, out_row_end_q, out_image_end_q;
	turns_t            out_turns_q;
	logic [PIX_W-1:0]  out_pixel_q;

	logic              accept, ld_fire, rd_fire, advance;
	logic [31:0]       px_ext;
	logic [PIXEL_BITS-1:0] px_wr, px_rd;
	logic [31:0]       rd_ext;
	logic              px_zero;
	logic              ld_col_end, ld_row_last, rd_col_end, rd_row_last;
	turns_t            turns;
	logic [AW-1:0]     start_addr, cur_addr, rs_addr, next_addr;
	logic [AW-1:0]     ram_raddr;

	// clamp the written side into 1..MAX_SIDE
	always_comb begin
		if (cfg_data == '0)                side_new = SIDE_W'(1);
		else if (int'(cfg_data) > MAX_SIDE) side_new = SIDE_W'(MAX_SIDE);
		else                               side_new = SIDE_W'(cfg_data);
	end

	assign stride = AW'(side_q);

	// handshake: hold input while the read stage is full and cannot drain
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !(valid_s1 && !advance);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign ld_fire       = accept && !s_axis_tuser && !full_q;
	assign rd_fire       = accept &&  s_axis_tuser &&  full_q;

	assign px_ext  = 32'(s_axis_tdata);
	assign px_wr   = px_ext[PIXEL_BITS-1:0];
	assign px_zero = (px_wr == '0);

	assign ld_col_end  = (ld_col_q == side_m1_q);
	assign ld_row_last = (ld_row_q == side_m1_q);
	assign rd_col_end  = (rd_col_q == side_m1_q);
	assign rd_row_last = (rd_row_q == side_m1_q);

	assign turns = pick_turns(flags_q);

	// first pixel address of the turned image
	always_comb begin
		unique case (turns)
			TURN_NONE:  start_addr = '0;
			TURN_ONE:   start_addr = AW'(side_m1_q);
			TURN_TWO:   start_addr = last_addr_q;
			TURN_THREE: start_addr = last_addr_q - AW'(side_m1_q);
			default:    start_addr = '0;
		endcase
	end

	assign cur_addr = (rd_row_q == '0 && rd_col_q == '0) ? start_addr : rd_addr_q;
	assign rs_addr  = (rd_col_q == '0) ? cur_addr : rd_rs_q;

	// step along an output row; at row end jump from the row's start
	always_comb begin
		unique case (turns)
			TURN_NONE:  next_addr = cur_addr + AW'(1);
			TURN_TWO:   next_addr = cur_addr - AW'(1);
			TURN_ONE:   next_addr = rd_col_end ? rs_addr - AW'(1) : cur_addr + stride;
			TURN_THREE: next_addr = rd_col_end ? rs_addr + AW'(1) : cur_addr - stride;
			default:    next_addr = cur_addr;
		endcase
	end

	assign ram_raddr = cur_addr;

	sqrot_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ld_fire),
		.waddr(ld_addr_q),
		.wdata(px_wr),
		.re   (rd_fire),
		.raddr(ram_raddr),
		.rdata(px_rd)
	);

	assign rd_ext = 32'(px_rd);

	// counters, flags and side register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q      <= SIDE_W'(RST_SIDE);
			side_m1_q   <= CW'(RST_SIDE - 1);
			ld_row_q    <= '0;
			ld_col_q    <= '0;
			ld_addr_q   <= '0;
			last_addr_q <= '0;
			full_q      <= 1'b0;
			flags_q     <= '0;
			rd_row_q    <= '0;
			rd_col_q    <= '0;
			rd_addr_q   <= '0;
			rd_rs_q     <= '0;
		end else if (cfg_we) begin
			// new side drops whatever image was in flight
			side_q    <= side_new;
			side_m1_q <= CW'(side_new - SIDE_W'(1));
			ld_row_q  <= '0;
			ld_col_q  <= '0;
			ld_addr_q <= '0;
			full_q    <= 1'b0;
			flags_q   <= '0;
			rd_row_q  <= '0;
			rd_col_q  <= '0;
		end else if (ld_fire) begin
			if (px_zero) begin
				if (ld_row_q == '0 && ld_col_end) flags_q.top_right <= 1'b1;
				if (ld_row_last && ld_col_end)    flags_q.bot_right <= 1'b1;
				if (ld_row_last && ld_col_q == '0) flags_q.bot_left <= 1'b1;
			end
			ld_addr_q <= ld_addr_q + AW'(1);
			if (ld_col_end) begin
				ld_col_q <= '0;
				ld_row_q <= ld_row_q + CW'(1);
				if (ld_row_last) begin
					full_q      <= 1'b1;
					last_addr_q <= ld_addr_q;
				end
			end else begin
				ld_col_q <= ld_col_q + CW'(1);
			end
		end else if (rd_fire) begin
			rd_addr_q <= next_addr;
			rd_rs_q   <= rs_addr;
			if (rd_col_end) begin
				rd_col_q <= '0;
				if (rd_row_last) begin
					// image drained: open up for the next load
					rd_row_q  <= '0;
					ld_row_q  <= '0;
					ld_col_q  <= '0;
					ld_addr_q <= '0;
					full_q    <= 1'b0;
					flags_q   <= '0;
				end else begin
					rd_row_q <= rd_row_q + CW'(1);
				end
			end else begin
				rd_col_q <= rd_col_q + CW'(1);
			end
		end
	end

	// store read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_fire) begin
			row_end_s1   <= rd_col_end;
			image_end_s1 <= rd_col_end && rd_row_last;
			turns_s1     <= turns;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_pixel_q     <= rd_ext[PIX_W-1:0];
			out_row_end_q   <= row_end_s1;
			out_image_end_q <= image_end_s1;
			out_turns_q     <= turns_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_pixel_q;
	assign m_axis_tlast  = out_row_end_q;
	assign m_axis_tuser  = {out_turns_q, out_image_end_q};

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for square_image_corner_orient_rotate: table-driven directed
// beats, then random images checked against an in-bench orientation predictor.
// Depends on sqrot_pkg and the block's RTL only.
module tb;
	import sqrot_pkg::*;

	localparam int          STORE_DEPTH   = DEF_MAX_SIDE * DEF_MAX_SIDE;
	localparam int          IDLE_PCT      = 31;
	localparam int          SETTLE_CYCLES = 4;   // margin over the store read and output registers
	localparam int          RAND_ITEMS    = 1900;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam logic        MODE_LOAD     = 1'b0;
	localparam logic        MODE_READ     = 1'b1;

	typedef enum logic [1:0] {
		OP_CFG,
		OP_LOAD,
		OP_READ
	} op_t;

	// one output beat as the block should present it
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             row_end;
		logic             image_end;
		turns_t           turns;
	} oriented_px_t;

	// directed row: chk set means the expected beat is typed in here
	typedef struct packed {
		op_t              op;
		logic [PIX_W-1:0] data;
		logic             chk;
		logic [PIX_W-1:0] e_pix;
		logic             e_row;
		logic             e_img;
		turns_t           e_turns;
	} dir_row_t;

	localparam int DIR_N = 27;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata;    // [15:0] pixel_in
	logic                  s_axis_tuser;    // [0] mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [PIX_W-1:0]      m_axis_tdata;    // [15:0] pixel_out
	logic                  m_axis_tlast;    // row_end
	logic [OUT_USER_W-1:0] m_axis_tuser;    // [0] image_end, [2:1] turns_applied

	// predictor copy of the block state
	logic [PIX_W-1:0] img_mem [0:STORE_DEPTH-1];
	logic [CFG_W-1:0] side_reg;
	int unsigned      load_cnt;
	int unsigned      read_cnt;
	corner_flags_t    zero_at;

	oriented_px_t     oriented_q [$];
	int unsigned      err_cnt = 0;
	int unsigned      cycle_cnt = 0;
	int unsigned      done_items;
	logic             no_idle;

	dir_row_t dir_tab [0:DIR_N-1] = '{
		// read on an empty image right after reset: nothing comes back
		'{OP_READ, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		// side 0 acts as 1; a lone zero pixel sits in every corner
		'{OP_CFG,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_LOAD, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_LOAD, 16'h1234, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},   // image full: dropped
		'{OP_READ, 16'hFFFF, 1'b1, 16'h0000, 1'b1, 1'b1, TURN_ONE},
		'{OP_CFG,  16'h0001, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_LOAD, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_READ, 16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b1, TURN_NONE},
		// 2x2, zero top-right: one quarter turn
		'{OP_CFG,  16'h0002, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_LOAD, 16'h0005, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_READ, 16'h5A5A, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},   // not full yet
		'{OP_LOAD, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_LOAD, 16'h0007, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_LOAD, 16'h0009, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_READ, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0, TURN_ONE},
		'{OP_READ, 16'h0000, 1'b1, 16'h0009, 1'b1, 1'b0, TURN_ONE},
		'{OP_READ, 16'h0000, 1'b1, 16'h0005, 1'b0, 1'b0, TURN_ONE},
		'{OP_READ, 16'h0000, 1'b1, 16'h0007, 1'b1, 1'b1, TURN_ONE},
		// 2x2, zero bottom-right only: half turn
		'{OP_LOAD, 16'h8000, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_LOAD, 16'h0001, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_LOAD, 16'h7FFF, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_LOAD, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE},
		'{OP_READ, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0, TURN_TWO},
		'{OP_READ, 16'h0000, 1'b1, 16'h7FFF, 1'b1, 1'b0, TURN_TWO},
		'{OP_READ, 16'h0000, 1'b1, 16'h0001, 1'b0, 1'b0, TURN_TWO},
		'{OP_READ, 16'h0000, 1'b1, 16'h8000, 1'b1, 1'b1, TURN_TWO},
		// side above the maximum acts as the maximum; the partial image is
		// dropped by the next side write
		'{OP_CFG,  16'h007F, 1'b0, 16'h0000, 1'b0, 1'b0, TURN_NONE}
	};

	square_image_corner_orient_rotate u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// side 0 acts as 1, anything above the maximum acts as the maximum
	function automatic int unsigned eff_side();
		if (side_reg == '0)
			return 1;
		if (side_reg > DEF_MAX_SIDE)
			return DEF_MAX_SIDE;
		return side_reg;
	endfunction

	// Advance the predicted state by one accepted beat. eff flags a beat the
	// block acts on (stored load or answered read); got flags an output beat.
	task automatic orient_predict(input logic mode, input logic [PIX_W-1:0] px,
			output logic eff, output logic got, output oriented_px_t res);
		int unsigned n;
		int unsigned total;
		int unsigned r;
		int unsigned c;
		int unsigned sr;
		int unsigned sc;
		turns_t      tn;
		n     = eff_side();
		total = n * n;
		eff   = 1'b0;
		got   = 1'b0;
		res   = '0;
		if (mode == MODE_LOAD) begin
			// drop loads once the image is full
			if (load_cnt < total) begin
				r = load_cnt / n;
				c = load_cnt % n;
				img_mem[load_cnt] = px;
				if (px == '0) begin
					if (r == 0 && c == n - 1)
						zero_at.top_right = 1'b1;
					if (r == n - 1 && c == n - 1)
						zero_at.bot_right = 1'b1;
					if (r == n - 1 && c == 0)
						zero_at.bot_left = 1'b1;
				end
				load_cnt++;
				eff = 1'b1;
			end
		end else if (load_cnt >= total && read_cnt < total) begin
			r = read_cnt / n;
			c = read_cnt % n;
			// top-right zero wins, then bottom-right, then bottom-left
			if (zero_at.top_right)
				tn = TURN_ONE;
			else if (zero_at.bot_right)
				tn = TURN_TWO;
			else if (zero_at.bot_left)
				tn = TURN_THREE;
			else
				tn = TURN_NONE;
			case (tn)
				TURN_ONE: begin
					sr = c;
					sc = n - 1 - r;
				end
				TURN_TWO: begin
					sr = n - 1 - r;
					sc = n - 1 - c;
				end
				TURN_THREE: begin
					sr = n - 1 - c;
					sc = r;
				end
				default: begin
					sr = r;
					sc = c;
				end
			endcase
			res.pixel     = img_mem[sr * n + sc];
			res.row_end   = (c == n - 1);
			res.image_end = (read_cnt == total - 1);
			res.turns     = tn;
			read_cnt++;
			eff = 1'b1;
			got = 1'b1;
			// drained: the next image may load
			if (read_cnt >= total) begin
				load_cnt = 0;
				read_cnt = 0;
				zero_at  = '0;
			end
		end
	endtask

	// Offer one beat, hold it until accepted, then record what it should yield.
	// A typed expectation, when given, stands in for the predicted one.
	task automatic send_beat(input logic mode, input logic [PIX_W-1:0] px,
			input logic chk, input oriented_px_t typed);
		logic         eff;
		logic         got;
		oriented_px_t res;
		if (!no_idle) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		orient_predict(mode, px, eff, got, res);
		if (chk)
			oriented_q.push_back(typed);
		else if (got)
			oriented_q.push_back(res);
		if (eff)
			done_items++;
	endtask

	// Write the side only once the block has gone quiet: every expected beat
	// back, then a wait of SETTLE_CYCLES for a load still in flight.
	task automatic write_side(input logic [CFG_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		while (oriented_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		side_reg = v;
		load_cnt = 0;
		read_cnt = 0;
		zero_at  = '0;
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		if ($urandom_range(0, 99) < 5)
			return '0;
		return PIX_W'($urandom);
	endfunction

	// Load up to loads pixels and then issue reads read beats, with stray
	// reads before full and stray loads while full mixed in as noise.
	task automatic load_and_read(input int unsigned loads, input int unsigned reads);
		int unsigned      n;
		int unsigned      idx;
		logic [2:0]       zc;
		logic [PIX_W-1:0] px;
		n  = eff_side();
		zc = {$urandom_range(0, 99) < 35, $urandom_range(0, 99) < 35,
			$urandom_range(0, 99) < 35};
		for (idx = 0; idx < loads; idx++) begin
			if ($urandom_range(0, 99) < 4)
				send_beat(MODE_READ, PIX_W'($urandom), 1'b0, '0);
			px = rand_pixel();
			// force the chosen corners to zero, else leave them random
			if (idx == n - 1 && zc[0])
				px = '0;
			if (idx == n * n - 1 && zc[1])
				px = '0;
			if (idx == (n - 1) * n && zc[2])
				px = '0;
			send_beat(MODE_LOAD, px, 1'b0, '0);
		end
		for (idx = 0; idx < reads; idx++) begin
			if ($urandom_range(0, 99) < 4)
				send_beat(MODE_LOAD, rand_pixel(), 1'b0, '0);
			send_beat(MODE_READ, PIX_W'($urandom), 1'b0, '0);
		end
	endtask

	function automatic logic [CFG_W-1:0] rand_side();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return '0;
		if (pick < 85)
			return CFG_W'($urandom_range(1, 6));
		return CFG_W'($urandom_range(7, 16));
	endfunction

	// One random image: mostly complete load and drain, sometimes a side write
	// that drops the image halfway through loading or reading.
	task automatic run_random_image(input logic force_cfg);
		int unsigned total;
		int unsigned kind;
		if (force_cfg || $urandom_range(0, 1) == 0)
			write_side(rand_side());
		// a long stretch in the middle of the run with no idling on either side
		no_idle = (done_items >= 700 && done_items < 1100);
		total   = eff_side() * eff_side();
		kind    = $urandom_range(0, 99);
		if (kind < 75) begin
			load_and_read(total, total);
		end else if (kind < 87) begin
			load_and_read($urandom_range(0, total - 1), $urandom_range(0, 2));
			write_side(rand_side());
		end else begin
			load_and_read(total, $urandom_range(0, total - 1));
			write_side(rand_side());
		end
	endtask

	// Output side: random back-pressure, compare every accepted beat in order.
	always @(posedge clk) begin
		oriented_px_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (oriented_q.size() == 0) begin
				$error("output beat with nothing expected: pixel_out %h", m_axis_tdata);
				err_cnt++;
			end else begin
				want = oriented_q.pop_front();
				if (m_axis_tdata !== want.pixel) begin
					$error("pixel_out: expected %h, actual %h", want.pixel, m_axis_tdata);
					err_cnt++;
				end
				if (m_axis_tlast !== want.row_end) begin
					$error("row_end: expected %b, actual %b", want.row_end, m_axis_tlast);
					err_cnt++;
				end
				if (m_axis_tuser[0] !== want.image_end) begin
					$error("image_end: expected %b, actual %b", want.image_end,
						m_axis_tuser[0]);
					err_cnt++;
				end
				if (m_axis_tuser[2:1] !== want.turns) begin
					$error("turns_applied: expected %0d, actual %0d", want.turns,
						m_axis_tuser[2:1]);
					err_cnt++;
				end
			end
		end
		m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		dir_row_t     row;
		oriented_px_t typed;
		int           k;
		done_items    = 0;
		no_idle       = 1'b0;
		side_reg      = CFG_W'(SIDE_RESET);
		load_cnt      = 0;
		read_cnt      = 0;
		zero_at       = '0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= MODE_LOAD;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (k = 0; k < DIR_N; k++) begin
			row   = dir_tab[k];
			typed = '{row.e_pix, row.e_row, row.e_img, row.e_turns};
			case (row.op)
				OP_CFG:  write_side(row.data[CFG_W-1:0]);
				OP_LOAD: send_beat(MODE_LOAD, row.data, row.chk, typed);
				default: send_beat(MODE_READ, row.data, row.chk, typed);
			endcase
		end
		// one load into the maximum-side image, then drop it with the next write
		send_beat(MODE_LOAD, 16'h0000, 1'b0, '0);

		// random images, small sides
		done_items = 0;
		run_random_image(1'b1);
		while (done_items < RAND_ITEMS)
			run_random_image(1'b0);

		// drain and let the pipeline settle
		s_axis_tvalid <= 1'b0;
		while (oriented_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
design/sqrot_pkg.sv
design/sqrot_ram.sv
design/square_image_corner_orient_rotate.sv
verif/tb.sv
